// File: sv/box_blur_3x3_edge_mean_assert.svh
// Assertion helpers for the box blur block.
// Both expect clk and rst_n in scope and are off while reset is asserted.
`ifndef BOX_BLUR_3X3_EDGE_MEAN_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_MEAN_ASSERT_SVH

// same-cycle implication
`define BBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bbm_pkg.sv
`default_nettype none

package bbm_pkg;

  localparam int PIX_W       = 8;
  localparam int FW_W        = 11;
  localparam int FH_W        = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int SUM_W       = 12;   // 9 * 255 = 2295
  localparam int RCP_W       = 17;
  localparam int RCP_SHIFT   = 16;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 16'd768;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // [row: r-2, r-1, r][col: c-2, c-1, c]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // first window row / column that lies inside the frame
  typedef struct packed {
    logic [1:0] rlo;
    logic [1:0] clo;
  } win_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL
  } state_t;

  // ceil(2^16 / count); exact truncated quotient for every sum up to 2295
  function automatic logic [RCP_W-1:0] get_recip(input win_sel_t sel);
    logic [RCP_W-1:0] rcp;
    unique case ({sel.rlo, sel.clo})
      4'b0000: rcp = 17'd7282;    // 9 cells
      4'b0001: rcp = 17'd10923;   // 6
      4'b0010: rcp = 17'd21846;   // 3
      4'b0100: rcp = 17'd10923;   // 6
      4'b0101: rcp = 17'd16384;   // 4
      4'b0110: rcp = 17'd32768;   // 2
      4'b1000: rcp = 17'd21846;   // 3
      4'b1001: rcp = 17'd32768;   // 2
      4'b1010: rcp = 17'd65536;   // 1
      default: rcp = 17'd65536;
    endcase
    return rcp;
  endfunction

endpackage

`default_nettype wire

// File: sv/box_blur_3x3_edge_mean.sv
// 3x3 box mean over a raster-order 8-bit pixel stream.
// in_*  : one pixel per beat (valid/ready), raster order, frame set by config.
// out_* : one mean per beat; row_end / frame_end tag the last column / pixel,
//         last_of_run tags the last result caused by one input pixel.
// cfg_* : register writes, index 0 = frame_width, 1 = frame_height; always ready.
// Results run one row and one column behind the input; the last row and each
// row end are flushed as extra results, up to 4 per input pixel.
// Sequence: an input beat takes a line buffer read, then write back and
// window shift, and each result takes a masked sum, then a reciprocal
// multiply; the shared mean unit and the single line buffer port set this.
// The next input beat is taken only after the last result of a pixel has
// left the multiply stage for the output register.
// The last result of a pixel may wait in the output register while the next
// pixel is taken. If the receiver stalls, the sequencer holds the next result
// in the multiply stage until the output register frees up.
// Reset: counters and window go to zero, width 1024, height 768. The line
// buffer is not cleared; entries are only read for rows above the frame,
// which never reach a result.
`default_nettype none

module box_blur_3x3_edge_mean import bbm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_mean_value,
  output logic                  out_row_end,
  output logic                  out_frame_end,
  output logic                  out_last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "box_blur_3x3_edge_mean_assert.svh"

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (MW_W > FW_W) ? MW_W : FW_W;

  // config
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state_r, state_nxt;
  logic   in_fire, upd, mean_load, out_load, slot_free;

  logic [AW-1:0]    column_count_r;
  logic [FH_W-1:0]  row_count_r;
  logic [PIX_W-1:0] pix_r;
  win_t             win_r;

  // one line buffer entry: [15:8] row r-2, [7:0] row r-1
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;

  logic [3:0] res_en, pending_r, pick, pick_r;
  logic [1:0] rlo_prev_r, rlo_last_r, clo_mid_r, clo_end_r;
  win_sel_t   sel;

  // per-pixel geometry
  logic [CMP_W-1:0] c_inc;
  logic [FH_W:0]    r_inc;
  logic             row_end, last_row;
  logic [1:0]       rlo_prev, rlo_last, clo_mid, clo_end;

  assign c_inc    = CMP_W'(column_count_r) + CMP_W'(1);
  assign r_inc    = (FH_W+1)'(row_count_r) + (FH_W+1)'(1);
  // width 0 acts as 1, width past the buffer acts as the buffer size
  assign row_end  = (c_inc >= CMP_W'(frame_width_r)) || (c_inc >= CMP_W'(MAX_WIDTH));
  assign last_row = r_inc >= (FH_W+1)'(frame_height_r);
  assign rlo_prev = (row_count_r >= FH_W'(2)) ? 2'd0 : 2'd1;
  assign rlo_last = (row_count_r >= FH_W'(1)) ? 2'd1 : 2'd2;
  assign clo_mid  = (column_count_r >= AW'(2)) ? 2'd0 : 2'd1;
  assign clo_end  = (column_count_r >= AW'(1)) ? 2'd1 : 2'd2;

  // result order: (r-1,c-1), (r,c-1), (r-1,W-1), (r,W-1)
  assign res_en[0] = (column_count_r != '0) && (row_count_r != '0);
  assign res_en[1] = (column_count_r != '0) && last_row;
  assign res_en[2] = row_end && (row_count_r != '0);
  assign res_en[3] = row_end && last_row;

  assign pick      = pending_r & (~pending_r + 4'd1);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = (res_en != '0) ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (slot_free) begin
          state_nxt = ((pending_r & ~pick_r) != '0) ? ST_SUM : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    upd       = (state_r == ST_READ);
    mean_load = (state_r == ST_SUM);
    out_load  = (state_r == ST_MUL) && slot_free;
    in_fire   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line buffer: read at accept, write back in the next cycle, no overlap
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= line_mem[column_count_r];
    end
    if (upd) begin
      line_mem[column_count_r] <= {rd_data_r[PIX_W-1:0], pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r <= in_pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      win_r          <= '0;
      pending_r      <= '0;
      pick_r         <= '0;
    end else begin
      if (upd) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= rd_data_r[2*PIX_W-1:PIX_W];
        win_r[1][2] <= rd_data_r[PIX_W-1:0];
        win_r[2][2] <= pix_r;
        pending_r   <= res_en;
        if (row_end) begin
          column_count_r <= '0;
          row_count_r    <= last_row ? '0 : r_inc[FH_W-1:0];
        end else begin
          column_count_r <= c_inc[AW-1:0];
        end
      end
      if (mean_load) begin
        pick_r <= pick;
      end
      if (out_load) begin
        pending_r <= pending_r & ~pick_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      rlo_prev_r <= rlo_prev;
      rlo_last_r <= rlo_last;
      clo_mid_r  <= clo_mid;
      clo_end_r  <= clo_end;
    end
  end

  always_comb begin
    sel.rlo = (pick[0] || pick[2]) ? rlo_prev_r : rlo_last_r;
    sel.clo = (pick[0] || pick[1]) ? clo_mid_r : clo_end_r;
  end

  logic [PIX_W-1:0] mean;

  bbm_mean u_mean (
    .clk  (clk),
    .load (mean_load),
    .win  (win_r),
    .sel  (sel),
    .mean (mean)
  );

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_mean_value_r;
  logic             out_row_end_r, out_frame_end_r, out_last_of_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_value_r  <= mean;
      out_row_end_r     <= pick_r[2] || pick_r[3];
      out_frame_end_r   <= pick_r[3];
      out_last_of_run_r <= (pending_r & ~pick_r) == '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mean_value  = out_mean_value_r;
  assign out_row_end     = out_row_end_r;
  assign out_frame_end   = out_frame_end_r;
  assign out_last_of_run = out_last_of_run_r;

  // checks
  `BBM_ASSERT_IMP(a_idle_clean, state_r == ST_IDLE, pending_r == '0, "results left in idle")
  `BBM_ASSERT_IMP(a_run_busy, out_valid && out_ready && !out_last_of_run,
    state_r == ST_SUM || state_r == ST_MUL, "run ended before its last result")
  `BBM_ASSERT_IMP(a_frame_tag, out_valid && out_frame_end,
    out_row_end && out_last_of_run, "frame end without row end")
  `BBM_ASSERT_NXT(a_stall_hold, state_r == ST_MUL && !slot_free,
    state_r == ST_MUL && $stable(pick_r), "result lost while stalled")

endmodule

`default_nettype wire

// File: sv/bbm_mean.sv
`default_nettype none

// Masked window sum and reciprocal in one stage, multiply after the register.
module bbm_mean import bbm_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  win_t             win,
  input  win_sel_t         sel,
  output logic [PIX_W-1:0] mean
);

  logic [SUM_W-1:0]       sum_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [RCP_W-1:0]       recip_r;
  logic [SUM_W+RCP_W-1:0] product;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((2'(i) >= sel.rlo) && (2'(j) >= sel.clo)) begin
          sum_nxt = sum_nxt + SUM_W'(win[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r   <= sum_nxt;
      recip_r <= get_recip(sel);
    end
  end

  assign product = (SUM_W+RCP_W)'(sum_r) * (SUM_W+RCP_W)'(recip_r);
  assign mean    = product[RCP_SHIFT +: PIX_W];

endmodule

`default_nettype wire
